>>> sv/ats_pkg.sv
// Shared constants and types for the affine texture sampler.
package ats_pkg;

    localparam int FRAC_BITS = 16;
    localparam int MAX_DIM   = 64;
    localparam int STORE_AW  = 12;
    localparam int STORE_DEPTH = 1 << STORE_AW;
    localparam int COORD_W   = 12;
    localparam int TEXEL_W   = 32;
    localparam int DIM_W     = 8;

    // source coordinate scale is 2^(FRAC_BITS+1): half-pixel centre needs one bit
    localparam int U_SH  = FRAC_BITS + 1;
    localparam int S_W   = 48;
    localparam int H_W   = S_W - U_SH;
    localparam int DIG   = 5;
    localparam int MSTG  = (H_W - 1 + DIG - 1) / DIG;
    localparam int A_W   = DIG * MSTG;
    localparam int MOD_W = DIM_W + 2;
    localparam int T_W   = U_SH + MOD_W + 1;

    localparam int XF_LAT   = 2;
    localparam int AX_LAT   = MSTG + 2;
    localparam int PIPE_LAT = XF_LAT + AX_LAT;

    localparam logic [1:0] TILE_REPEAT = 2'd1;
    localparam logic [1:0] TILE_MIRROR = 2'd2;

    localparam logic ACT_SHADE = 1'b0;
    localparam logic ACT_LOAD  = 1'b1;

    localparam int CFG_AW = 3;
    localparam logic [CFG_AW-1:0] REG_SX_X  = 3'd0;
    localparam logic [CFG_AW-1:0] REG_SX_Y  = 3'd1;
    localparam logic [CFG_AW-1:0] REG_OFF_X = 3'd2;
    localparam logic [CFG_AW-1:0] REG_SY_X  = 3'd3;
    localparam logic [CFG_AW-1:0] REG_SY_Y  = 3'd4;
    localparam logic [CFG_AW-1:0] REG_OFF_Y = 3'd5;
    localparam logic [CFG_AW-1:0] REG_MODE  = 3'd6;
    localparam logic [CFG_AW-1:0] REG_SIZE  = 3'd7;

    typedef struct packed {
        logic                act;
        logic                last;
        logic [STORE_AW-1:0] tidx;
        logic [TEXEL_W-1:0]  tval;
    } t_side;

endpackage

>>> sv/ats_xform.sv
// Inverse affine transform of the pixel centre: multiply stage, then sum stage.
module ats_xform (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [11:0]        i_px,
    input  logic [11:0]        i_py,
    input  logic signed [31:0] i_sx_x,
    input  logic signed [31:0] i_sx_y,
    input  logic signed [31:0] i_off_x,
    input  logic signed [31:0] i_sy_x,
    input  logic signed [31:0] i_sy_y,
    input  logic signed [31:0] i_off_y,
    output logic signed [ats_pkg::S_W-1:0] o_sx,
    output logic signed [ats_pkg::S_W-1:0] o_sy
);

    logic signed [13:0] px2;
    logic signed [13:0] py2;
    logic signed [45:0] r_p_xx, r_p_xy, r_p_yx, r_p_yy;
    logic signed [ats_pkg::S_W-1:0] r_sx, r_sy;

    // 2*p + 1 keeps the pixel centre exact
    assign px2 = $signed({1'b0, i_px, 1'b1});
    assign py2 = $signed({1'b0, i_py, 1'b1});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_xx <= i_sx_x * px2;
            r_p_xy <= i_sx_y * py2;
            r_p_yx <= i_sy_x * px2;
            r_p_yy <= i_sy_y * py2;
            r_sx <= ats_pkg::S_W'(r_p_xx) + ats_pkg::S_W'(r_p_xy)
                  + ats_pkg::S_W'($signed({i_off_x, 1'b0}));
            r_sy <= ats_pkg::S_W'(r_p_yx) + ats_pkg::S_W'(r_p_yy)
                  + ats_pkg::S_W'($signed({i_off_y, 1'b0}));
        end
    end

    assign o_sx = r_sx;
    assign o_sy = r_sy;

endmodule

>>> sv/ats_axis.sv
// One axis: tiling of the source coordinate with a pipelined remainder unit.
module ats_axis (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic signed [ats_pkg::S_W-1:0] i_s,
    input  logic [ats_pkg::DIM_W-1:0]      i_size_m1,
    input  logic [1:0]                     i_mode,
    output logic [ats_pkg::DIM_W-1:0]      o_idx
);

    localparam int MW = ats_pkg::MOD_W;

    logic [ats_pkg::DIM_W:0]   w_size;
    logic [MW-1:0]             w_mod;
    logic                      s_neg;
    logic [ats_pkg::H_W-1:0]   s_hi;
    logic [ats_pkg::S_W-1:0]   s_rnd;
    logic [ats_pkg::DIM_W-1:0] s_cidx;

    logic [MW-1:0]               r_rem  [0:ats_pkg::MSTG];
    logic [ats_pkg::A_W-1:0]     r_a    [0:ats_pkg::MSTG];
    logic                        r_neg  [0:ats_pkg::MSTG];
    logic [ats_pkg::U_SH-1:0]    r_low  [0:ats_pkg::MSTG];
    logic [ats_pkg::DIM_W-1:0]   r_cidx [0:ats_pkg::MSTG];
    logic [ats_pkg::DIM_W-1:0]   r_idx;

    assign w_size = {1'b0, i_size_m1} + 1'b1;
    assign w_mod  = (i_mode == ats_pkg::TILE_MIRROR) ? {w_size, 1'b0} : {1'b0, w_size};

    // first stage: split off the integer part, fold negatives, clamp index
    always_comb begin
        s_neg = i_s[ats_pkg::S_W-1];
        s_hi  = i_s[ats_pkg::S_W-1:ats_pkg::U_SH];
        s_rnd = i_s + (ats_pkg::S_W'(1) << ats_pkg::FRAC_BITS);
        if (s_neg) begin
            s_cidx = '0;
        end else if (s_rnd[ats_pkg::S_W-1:ats_pkg::U_SH] > ats_pkg::H_W'(i_size_m1)) begin
            s_cidx = i_size_m1;
        end else begin
            s_cidx = s_rnd[ats_pkg::U_SH +: ats_pkg::DIM_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= '0;
            r_a[0]    <= s_neg ? ats_pkg::A_W'(~s_hi) : ats_pkg::A_W'(s_hi);
            r_neg[0]  <= s_neg;
            r_low[0]  <= i_s[ats_pkg::U_SH-1:0];
            r_cidx[0] <= s_cidx;
        end
    end

    // remainder stages: DIG restoring steps each, MSB first
    for (genvar k = 1; k <= ats_pkg::MSTG; k++) begin : g_mod
        logic [MW-1:0]           n_rem;
        logic [ats_pkg::A_W-1:0] n_a;

        always_comb begin
            logic [MW:0] t;
            n_rem = r_rem[k-1];
            n_a   = r_a[k-1];
            for (int j = 0; j < ats_pkg::DIG; j++) begin
                t = {n_rem, n_a[ats_pkg::A_W-1]};
                n_a = {n_a[ats_pkg::A_W-2:0], 1'b0};
                if (t >= {1'b0, w_mod}) begin
                    t = t - {1'b0, w_mod};
                end
                n_rem = t[MW-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_a[k]    <= n_a;
                r_neg[k]  <= r_neg[k-1];
                r_low[k]  <= r_low[k-1];
                r_cidx[k] <= r_cidx[k-1];
            end
        end
    end

    // last stage: floor remainder, mirror reflection, rounding, final clamp
    logic [MW-1:0]                 f_rem;
    logic [ats_pkg::T_W-1:0]       f_t;
    logic [ats_pkg::T_W-1:0]       f_span;
    logic [ats_pkg::T_W-1:0]       f_rnd;
    logic [ats_pkg::T_W-ats_pkg::U_SH-1:0] f_q;
    logic [ats_pkg::DIM_W-1:0]     n_idx;

    always_comb begin
        f_rem  = r_neg[ats_pkg::MSTG] ? (w_mod - 1'b1 - r_rem[ats_pkg::MSTG])
                                      : r_rem[ats_pkg::MSTG];
        f_t    = ats_pkg::T_W'({f_rem, r_low[ats_pkg::MSTG]});
        f_span = ats_pkg::T_W'(w_size) << ats_pkg::U_SH;
        if (i_mode == ats_pkg::TILE_MIRROR && f_t >= f_span) begin
            f_t = (ats_pkg::T_W'(w_mod) << ats_pkg::U_SH) - f_t;
        end
        f_rnd = f_t + (ats_pkg::T_W'(1) << ats_pkg::FRAC_BITS);
        f_q   = f_rnd[ats_pkg::T_W-1:ats_pkg::U_SH];
        if (i_mode != ats_pkg::TILE_REPEAT && i_mode != ats_pkg::TILE_MIRROR) begin
            n_idx = r_cidx[ats_pkg::MSTG];
        end else if (f_q > (ats_pkg::T_W-ats_pkg::U_SH)'(i_size_m1)) begin
            n_idx = i_size_m1;
        end else begin
            n_idx = f_q[ats_pkg::DIM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_idx <= n_idx;
        end
    end

    assign o_idx = r_idx;

endmodule

>>> sv/affine_texture_sampler_tiled.sv
// Top level of the affine nearest-neighbor texture sampler with tiling.
// Usage:
//   Input channel (i_valid/o_ready) takes one beat per item: action 0 shades
//   pixel (pixel_x, pixel_y), action 1 loads texel_value at texel_index.
//   Output channel (o_valid/i_ready) gives one beat per shade item: color,
//   sample_col, sample_row, span_end. Load items give no beat.
//   Config channel (i_cfg_valid/o_cfg_ready) writes register i_cfg_index with
//   i_cfg_data; it is always ready. Write registers only while the block is idle.
// Timing:
//   One item per cycle sustained while the receiver does not stall. A shade
//   item passes through two transform stages, one split stage, six
//   remainder stages of five quotient bits each, one tiling stage, and the
//   texel store read into the output register.
//   Loads write the store at the same stage where shades read it, so order
//   between loads and shades is kept.
// Reset and stall:
//   Reset empties the pipeline and restores the matrix to identity, clamp
//   mode and a 1x1 image. The texel store is not cleared: load before shading.
//   When the receiver holds i_ready low with a result waiting, the whole
//   pipeline holds and o_ready drops; nothing is lost or repeated.
module affine_texture_sampler_tiled (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_action,
    input  logic [ats_pkg::COORD_W-1:0]   i_pixel_x,
    input  logic [ats_pkg::COORD_W-1:0]   i_pixel_y,
    input  logic                          i_span_last,
    input  logic [ats_pkg::STORE_AW-1:0]  i_texel_index,
    input  logic [ats_pkg::TEXEL_W-1:0]   i_texel_value,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [ats_pkg::TEXEL_W-1:0]   o_color,
    output logic [ats_pkg::DIM_W-1:0]     o_sample_col,
    output logic [ats_pkg::DIM_W-1:0]     o_sample_row,
    output logic                          o_span_end,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ats_pkg::CFG_AW-1:0]    i_cfg_index,
    input  logic [31:0]                   i_cfg_data
);

    logic signed [31:0] r_sx_x, r_sx_y, r_off_x, r_sy_x, r_sy_y, r_off_y;
    logic [1:0]         r_mode;
    logic [15:0]        r_size;

    logic en;
    logic r_ov;
    logic r_vld [0:ats_pkg::PIPE_LAT-1];
    ats_pkg::t_side r_side [0:ats_pkg::PIPE_LAT-1];

    logic signed [ats_pkg::S_W-1:0] w_sx, w_sy;
    logic [ats_pkg::DIM_W-1:0] w_col, w_row;
    logic [ats_pkg::STORE_AW-1:0] w_raddr;
    ats_pkg::t_side w_tail;
    logic w_tail_v;

    logic [ats_pkg::TEXEL_W-1:0] r_store [0:ats_pkg::STORE_DEPTH-1];
    logic [ats_pkg::TEXEL_W-1:0] r_color;
    logic [ats_pkg::DIM_W-1:0]   r_col, r_row;
    logic                        r_end;

    // advance everything unless a result waits on a stalled receiver
    assign en          = !r_ov || i_ready;
    assign o_ready     = en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sx_x  <= 32'sd65536;
            r_sx_y  <= '0;
            r_off_x <= '0;
            r_sy_x  <= '0;
            r_sy_y  <= 32'sd65536;
            r_off_y <= '0;
            r_mode  <= '0;
            r_size  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ats_pkg::REG_SX_X:  r_sx_x  <= i_cfg_data;
                ats_pkg::REG_SX_Y:  r_sx_y  <= i_cfg_data;
                ats_pkg::REG_OFF_X: r_off_x <= i_cfg_data;
                ats_pkg::REG_SY_X:  r_sy_x  <= i_cfg_data;
                ats_pkg::REG_SY_Y:  r_sy_y  <= i_cfg_data;
                ats_pkg::REG_OFF_Y: r_off_y <= i_cfg_data;
                ats_pkg::REG_MODE:  r_mode  <= i_cfg_data[1:0];
                ats_pkg::REG_SIZE:  r_size  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    ats_xform u_xform (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_px    (i_pixel_x),
        .i_py    (i_pixel_y),
        .i_sx_x  (r_sx_x),
        .i_sx_y  (r_sx_y),
        .i_off_x (r_off_x),
        .i_sy_x  (r_sy_x),
        .i_sy_y  (r_sy_y),
        .i_off_y (r_off_y),
        .o_sx    (w_sx),
        .o_sy    (w_sy)
    );

    ats_axis u_axis_x (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_s       (w_sx),
        .i_size_m1 (r_size[15:8]),
        .i_mode    (r_mode),
        .o_idx     (w_col)
    );

    ats_axis u_axis_y (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_s       (w_sy),
        .i_size_m1 (r_size[7:0]),
        .i_mode    (r_mode),
        .o_idx     (w_row)
    );

    // valid bits and sideband travel alongside the arithmetic
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ats_pkg::PIPE_LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < ats_pkg::PIPE_LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= '{act: i_action, last: i_span_last,
                           tidx: i_texel_index, tval: i_texel_value};
            for (int k = 1; k < ats_pkg::PIPE_LAT; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign w_tail   = r_side[ats_pkg::PIPE_LAT-1];
    assign w_tail_v = r_vld[ats_pkg::PIPE_LAT-1];
    assign w_raddr  = ats_pkg::STORE_AW'(
        {12'b0, w_row} * 20'(ats_pkg::MAX_DIM) + 20'(w_col));

    // one store access per cycle: write for a load, read for a shade
    always_ff @(posedge i_clk) begin
        if (en && w_tail_v) begin
            if (w_tail.act == ats_pkg::ACT_LOAD) begin
                r_store[w_tail.tidx] <= w_tail.tval;
            end else begin
                r_color <= r_store[w_raddr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_col <= w_col;
            r_row <= w_row;
            r_end <= w_tail.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= w_tail_v && (w_tail.act == ats_pkg::ACT_SHADE);
        end
    end

    assign o_valid      = r_ov;
    assign o_color      = r_color;
    assign o_sample_col = r_col;
    assign o_sample_row = r_row;
    assign o_span_end   = r_end;

endmodule

>>> verif/ats_checker.sv
// Watches the sampler channels, predicts each shaded texel and compares the results.
`timescale 1ns / 100ps
module ats_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_ready,
    input  logic        i_action,
    input  logic [11:0] i_pixel_x,
    input  logic [11:0] i_pixel_y,
    input  logic        i_span_last,
    input  logic [11:0] i_texel_index,
    input  logic [31:0] i_texel_value,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic [31:0] o_color,
    input  logic [7:0]  o_sample_col,
    input  logic [7:0]  o_sample_row,
    input  logic        o_span_end,
    input  logic        i_cfg_valid,
    input  logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);

    typedef struct packed {
        logic [31:0] color;
        logic [7:0]  col;
        logic [7:0]  row;
        logic        span_end;
    } t_texel_beat;

    logic [31:0] coef [8];
    logic [31:0] texels [4096];
    t_texel_beat texel_beats_due [$];

    assign o_pending = texel_beats_due.size();

    initial o_errors = 0;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        o_errors++;
    endtask

    function automatic longint floor_rem(longint a, longint m);
        longint r;
        r = a % m;
        if (r < 0) r += m;
        return r;
    endfunction

    // Map a source coordinate (scale 2^17) to a texel index for one axis.
    function automatic int tile_pos(longint s, int sz, logic [1:0] mode);
        longint unit, span, t, idx;
        unit = longint'(1) << (ats_pkg::FRAC_BITS + 1);
        span = sz * unit;
        if (mode == ats_pkg::TILE_REPEAT) begin
            t = floor_rem(s, span);
        end else if (mode == ats_pkg::TILE_MIRROR) begin
            t = floor_rem(s, 2 * span);
            if (t >= span) t = 2 * span - t;
        end else begin
            t = (s < 0) ? 0 : ((s > (sz - 1) * unit) ? (sz - 1) * unit : s);
        end
        idx = (t + (longint'(1) << ats_pkg::FRAC_BITS)) >>> (ats_pkg::FRAC_BITS + 1);
        if (idx > sz - 1) idx = sz - 1;
        return int'(idx);
    endfunction

    function automatic t_texel_beat shade(logic [11:0] px, logic [11:0] py, logic last);
        longint x2, y2, sx, sy;
        int w, h, c, r;
        t_texel_beat b;
        x2 = 2 * longint'(px) + 1;
        y2 = 2 * longint'(py) + 1;
        sx = longint'($signed(coef[ats_pkg::REG_SX_X])) * x2
             + longint'($signed(coef[ats_pkg::REG_SX_Y])) * y2
             + 2 * longint'($signed(coef[ats_pkg::REG_OFF_X]));
        sy = longint'($signed(coef[ats_pkg::REG_SY_X])) * x2
             + longint'($signed(coef[ats_pkg::REG_SY_Y])) * y2
             + 2 * longint'($signed(coef[ats_pkg::REG_OFF_Y]));
        w = int'(coef[ats_pkg::REG_SIZE][15:8]) + 1;
        h = int'(coef[ats_pkg::REG_SIZE][7:0]) + 1;
        c = tile_pos(sx, w, coef[ats_pkg::REG_MODE][1:0]);
        r = tile_pos(sy, h, coef[ats_pkg::REG_MODE][1:0]);
        b.color = texels[(r * ats_pkg::MAX_DIM + c) & (ats_pkg::STORE_DEPTH - 1)];
        b.col = c[7:0];
        b.row = r[7:0];
        b.span_end = last;
        return b;
    endfunction

    always @(posedge i_clk) begin
        t_texel_beat want;
        if (!i_rst_n) begin
            foreach (coef[k])
                coef[k] <= (k == int'(ats_pkg::REG_SX_X) || k == int'(ats_pkg::REG_SY_Y))
                           ? 32'd65536 : 32'd0;
            texel_beats_due.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == ats_pkg::REG_MODE)
                    coef[i_cfg_index] <= {30'd0, i_cfg_data[1:0]};
                else if (i_cfg_index == ats_pkg::REG_SIZE)
                    coef[i_cfg_index] <= {16'd0, i_cfg_data[15:0]};
                else coef[i_cfg_index] <= i_cfg_data;
            end
            if (i_valid && o_ready) begin
                if (i_action == ats_pkg::ACT_LOAD) texels[i_texel_index] = i_texel_value;
                else texel_beats_due.push_back(shade(i_pixel_x, i_pixel_y, i_span_last));
            end
            if (o_valid && i_ready) begin
                if (texel_beats_due.size() == 0) begin
                    report("unexpected beat color", o_color, 32'hx);
                end else begin
                    want = texel_beats_due.pop_front();
                    if (o_color !== want.color) report("color", o_color, want.color);
                    if (o_sample_col !== want.col) report("sample_col", o_sample_col, want.col);
                    if (o_sample_row !== want.row) report("sample_row", o_sample_row, want.row);
                    if (o_span_end !== want.span_end)
                        report("span_end", o_span_end, want.span_end);
                end
            end
        end
    end
endmodule

>>> verif/tb.sv
// Stimulus and verdict for the affine texture sampler.
`timescale 1ns / 100ps
module tb;

    localparam logic [1:0] TILE_CLAMP = 2'd0;
    localparam logic [1:0] TILE_ODD   = 2'd3;
    localparam int IDLE_LIMIT = 3000;
    localparam int HOLD_LEN   = 80;
    // shades only ever reach store entries below this with the sizes used here
    localparam int FILL_N     = 128;

    logic        i_clk = 1'b0, i_rst_n = 1'b0;
    logic        i_valid = 1'b0, o_ready;
    logic        i_action = 1'b0, i_span_last = 1'b0;
    logic [11:0] i_pixel_x = '0, i_pixel_y = '0, i_texel_index = '0;
    logic [31:0] i_texel_value = '0;
    logic        o_valid, i_ready = 1'b0;
    logic [31:0] o_color;
    logic [7:0]  o_sample_col, o_sample_row;
    logic        o_span_end;
    logic        i_cfg_valid = 1'b0, o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    int          errors, pending;
    int          idle_cyc = 0, hold_cnt = 0;
    bit          gaps = 1'b1, hold_req = 1'b0, hold_done = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    affine_texture_sampler_tiled DUT (.*);
    ats_checker checker_i (.*, .o_errors(errors), .o_pending(pending));

    // Receiver: random stalls, one long hold-off on request, none in the quiet stretch.
    always @(posedge i_clk) begin
        if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            hold_cnt <= HOLD_LEN;
            i_ready <= 1'b0;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
            i_ready <= 1'b0;
        end else if (!gaps) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(99) >= 30);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            idle_cyc <= 0;
        else
            idle_cyc <= idle_cyc + 1;
        if (idle_cyc >= IDLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    task automatic put_item(input logic act, input logic [11:0] px, input logic [11:0] py,
                            input logic last, input logic [11:0] idx, input logic [31:0] val);
        while (gaps && $urandom_range(99) < 30) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_action <= act;
        i_pixel_x <= px;
        i_pixel_y <= py;
        i_span_last <= last;
        i_texel_index <= idx;
        i_texel_value <= val;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic shade_px(input logic [11:0] px, input logic [11:0] py);
        put_item(ats_pkg::ACT_SHADE, px, py, 1'($urandom_range(1)), 12'($urandom), $urandom);
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        // loads may still be in flight with no beat due
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_map(input logic [31:0] a, b, c, d, e, f,
                           input logic [1:0] mode, input logic [15:0] size);
        drain();
        write_reg(ats_pkg::REG_SX_X, a);
        write_reg(ats_pkg::REG_SX_Y, b);
        write_reg(ats_pkg::REG_OFF_X, c);
        write_reg(ats_pkg::REG_SY_X, d);
        write_reg(ats_pkg::REG_SY_Y, e);
        write_reg(ats_pkg::REG_OFF_Y, f);
        write_reg(ats_pkg::REG_MODE, 32'(mode));
        write_reg(ats_pkg::REG_SIZE, 32'(size));
    endtask

    function automatic logic [31:0] pick_coef();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(262144)) - 131072);
            2: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: return 32'($signed($urandom_range(4096)) - 2048);
        endcase
    endfunction

    initial begin
        logic [15:0] sz;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill the entries that shades can reach: row * 64 + col below FILL_N
        for (int k = 0; k < FILL_N; k++)
            put_item(ats_pkg::ACT_LOAD, 12'($urandom), 12'($urandom), 1'($urandom_range(1)),
                     12'(k), $urandom);

        // reset mapping: 1x1 image
        shade_px(12'd0, 12'd0);
        shade_px(12'hFFF, 12'hFFF);
        put_item(ats_pkg::ACT_LOAD, 12'd5, 12'd9, 1'b1, 12'd0, 32'hFFFF_FFFF);
        shade_px(12'd3, 12'd7);

        set_map(32'h10000, 0, 0, 0, 32'h10000, 0, TILE_CLAMP, 16'h3F01);
        shade_px(12'd0, 12'd0);
        shade_px(12'd63, 12'd63);
        shade_px(12'hFFF, 12'd0);
        set_map(32'h10000, 0, 32'hFFF0_0000, 0, 32'h10000, 32'h0008_0000,
                ats_pkg::TILE_REPEAT, 16'h3F01);
        shade_px(12'd0, 12'd0);
        shade_px(12'd100, 12'hFFF);
        set_map(32'h18000, 32'h4000, 32'hFFF8_0000, 32'hFFFF_C000, 32'h10000, 0,
                ats_pkg::TILE_MIRROR, 16'h3F01);
        shade_px(12'd0, 12'd0);
        shade_px(12'd64, 12'd70);
        shade_px(12'hFFF, 12'hFFF);
        set_map(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h7FFF_FFFF, TILE_ODD, 16'h7F00);
        shade_px(12'hFFF, 12'hFFF);
        shade_px(12'd0, 12'hFFF);
        set_map(32'h7FFF_FFFF, 0, 0, 0, 32'h8000_0000, 0, ats_pkg::TILE_MIRROR, 16'h7F00);
        shade_px(12'hFFF, 12'd1);
        set_map(32'h10000, 0, 0, 0, 32'h10000, 0, ats_pkg::TILE_REPEAT, 16'h0000);
        shade_px(12'd77, 12'd12);
        shade_px(12'hFFF, 12'hFFF);

        for (int ph = 0; ph < 8; ph++) begin
            sz = ($urandom_range(1) == 0) ? {1'b0, 7'($urandom), 8'h00}
                                          : {2'b0, 6'($urandom), 7'b0, 1'($urandom)};
            set_map(pick_coef(), pick_coef(), pick_coef(), pick_coef(), pick_coef(),
                    pick_coef(), 2'($urandom), sz);
            repeat (20) begin
                if ($urandom_range(99) < 20)
                    put_item(ats_pkg::ACT_LOAD, 12'($urandom), 12'($urandom),
                             1'($urandom_range(1)), 12'($urandom), $urandom);
                else
                    shade_px(12'($urandom), 12'($urandom));
            end
        end

        // keep offering items while the receiver holds off
        hold_req <= 1'b1;
        repeat (40) shade_px(12'($urandom), 12'($urandom));

        // back-to-back stretch with no idling on either side
        gaps <= 1'b0;
        repeat (60) shade_px(12'($urandom), 12'($urandom));
        gaps <= 1'b1;

        drain();
        repeat (30) @(posedge i_clk);
        if (errors == 0 && pending == 0) $display("tb OK");
        else $display("tb NOT OK");
        $finish;
    end
endmodule

>>> affine_texture_sampler_tiled.f
sv/ats_pkg.sv
sv/ats_xform.sv
sv/ats_axis.sv
sv/affine_texture_sampler_tiled.sv
verif/ats_checker.sv
verif/tb.sv
